FILE: rtl/shs_pkg.sv
// Shared types, constants and round functions of the SHA-256 stream hasher.
package shs_pkg;

    typedef enum logic [2:0] {
        ST_IN,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_OUT
    } shs_state_t;

    typedef struct packed {
        logic absorb;
        logic pad;
        logic start;
        logic round;
        logic fold;
        logic emit;
        logic finish;
    } shs_cmd_t;

    typedef struct packed {
        logic fill_full;
        logic len_phase;
        logic round_last;
        logic word_last;
    } shs_status_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_FILL = 6'd56;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

FILE: rtl/shs_ctrl.sv
// Controller state machine of the SHA-256 stream hasher.
module shs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_present,
    input  logic               in_end,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  shs_pkg::shs_status_t status,
    output shs_pkg::shs_cmd_t    cmd
);
    import shs_pkg::*;

    shs_state_t state_reg, state_next;
    logic       end_pend_reg, end_pend_next;
    logic       final_reg, final_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IN;
            end_pend_reg <= 1'b0;
            final_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            end_pend_reg <= end_pend_next;
            final_reg    <= final_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        end_pend_next = end_pend_reg;
        final_next    = final_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        unique case (state_reg)
            ST_IN:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.absorb    = in_present;
                    end_pend_next = in_end;
                    if (in_present && status.fill_full)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_ROUND;
                    end
                    else if (in_end)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (status.round_last)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                cmd.fold = 1'b1;
                if (final_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (end_pend_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IN;
                end
            end
            ST_PAD:
            begin
                cmd.pad = 1'b1;
                if (status.fill_full)
                begin
                    cmd.start  = 1'b1;
                    final_next = status.len_phase;
                    state_next = ST_ROUND;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.emit = 1'b1;
                    if (status.word_last)
                    begin
                        cmd.finish    = 1'b1;
                        end_pend_next = 1'b0;
                        final_next    = 1'b0;
                        state_next    = ST_IN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IN;
            end
        endcase
    end

endmodule

FILE: rtl/shs_datapath.sv
// Datapath of the SHA-256 stream hasher: message window, rounds, chaining words.
module shs_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  shs_pkg::shs_cmd_t    cmd,
    input  logic [7:0]           in_byte,
    output shs_pkg::shs_status_t status,
    output logic [31:0]          digest_word,
    output logic [2:0]           word_index
);
    import shs_pkg::*;

    logic [31:0] chain_reg [8];
    logic [31:0] work_reg [8];
    logic [31:0] win_reg [16];
    logic [23:0] part_reg;
    logic [60:0] count_reg;
    logic [5:0]  fill_reg;
    logic [5:0]  round_reg;
    logic [2:0]  idx_reg;
    logic        pad_done_reg;
    logic        len_phase_reg;

    logic        insert;
    logic [7:0]  new_byte;
    logic [63:0] len_shift;
    logic [31:0] t1, t2, w_new;

    assign insert    = cmd.absorb | cmd.pad;
    assign len_shift = {count_reg, 3'b000} << {fill_reg[2:0], 3'b000};

    always_comb
    begin
        if (!cmd.pad)
        begin
            new_byte = in_byte;
        end
        else if (!pad_done_reg)
        begin
            new_byte = PAD_BYTE;
        end
        else if (len_phase_reg || fill_reg == LEN_FILL)
        begin
            new_byte = len_shift[63:56];
        end
        else
        begin
            new_byte = 8'h00;
        end
    end

    assign t1 = work_reg[7] + big_sigma1(work_reg[4])
              + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
              + ROUND_K[round_reg] + win_reg[0];
    assign t2 = big_sigma0(work_reg[0])
              + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
              ^ (work_reg[1] & work_reg[2]));
    assign w_new = small_sigma1(win_reg[14]) + win_reg[9]
                 + small_sigma0(win_reg[1]) + win_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= IV[i];
            end
            count_reg     <= '0;
            fill_reg      <= '0;
            round_reg     <= '0;
            idx_reg       <= '0;
            pad_done_reg  <= 1'b0;
            len_phase_reg <= 1'b0;
        end
        else
        begin
            if (insert)
            begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (cmd.absorb)
            begin
                count_reg <= count_reg + 61'd1;
            end
            if (cmd.pad)
            begin
                pad_done_reg <= 1'b1;
                if (pad_done_reg && fill_reg == LEN_FILL)
                begin
                    len_phase_reg <= 1'b1;
                end
            end
            if (cmd.start)
            begin
                round_reg <= '0;
            end
            else if (cmd.round)
            begin
                round_reg <= round_reg + 6'd1;
            end
            if (cmd.fold)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
                end
            end
            if (cmd.emit)
            begin
                idx_reg <= idx_reg + 3'd1;
            end
            if (cmd.finish)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= IV[i];
                end
                count_reg     <= '0;
                fill_reg      <= '0;
                pad_done_reg  <= 1'b0;
                len_phase_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (insert)
        begin
            if (fill_reg[1:0] == 2'd3)
            begin
                for (int i = 0; i < 15; i++)
                begin
                    win_reg[i] <= win_reg[i + 1];
                end
                win_reg[15] <= {part_reg, new_byte};
            end
            else
            begin
                part_reg <= {part_reg[15:0], new_byte};
            end
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w_new;
        end

        if (cmd.start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                work_reg[i] <= chain_reg[i];
            end
        end
        else if (cmd.round)
        begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
    end

    assign status.fill_full  = (fill_reg == 6'd63);
    assign status.len_phase  = len_phase_reg;
    assign status.round_last = (round_reg == 6'd63);
    assign status.word_last  = (idx_reg == 3'd7);

    assign digest_word = chain_reg[idx_reg];
    assign word_index  = idx_reg;

endmodule

FILE: rtl/sha256_stream_hasher_top.sv
// Top level of the SHA-256 stream hasher.
//
// The input stream takes one request per message byte: tdata carries the
// byte, tuser[0] says whether a byte is present, tlast ends the message.
// A request with tuser[0] low and tlast high ends an empty or complete
// message. The 64th byte of a block starts a compression of 64 rounds
// and a fold, during which input is held off. At the message end the
// block inserts padding one byte per cycle outside compressions, with
// one extra compression when the length does not fit, then sends eight
// digest words on the output stream, most significant first; tlast marks
// the last word. A stalled receiver holds the current word and input
// stays blocked until all eight words are taken; the hash then restarts
// from the initial value. Reset clears the byte count and loads the
// initial hash; the block is ready as soon as reset is released.
module sha256_stream_hasher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic [0:0]  s_axis_tuser,   // byte_present[0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // digest_word[31:0], word_index[34:32], zero[39:35]
    output logic        m_axis_tlast
);
    import shs_pkg::*;

    shs_cmd_t    cmd;
    shs_status_t status;
    logic [31:0] digest_word;
    logic [2:0]  word_index;

    shs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_present (s_axis_tuser[0]),
        .in_end     (s_axis_tlast),
        .in_ready   (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .status     (status),
        .cmd        (cmd)
    );

    shs_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_byte     (s_axis_tdata),
        .status      (status),
        .digest_word (digest_word),
        .word_index  (word_index)
    );

    assign m_axis_tdata = {5'b00000, word_index, digest_word};
    assign m_axis_tlast = status.word_last;

endmodule

FILE: rtl/shs_checker.sv
// Port-level assertions of the SHA-256 stream hasher and their binding.
module shs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output request dropped while stalled");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while digest is sent");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)))
        else $error("last mark out of step with word index");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid
            && (m_axis_tdata[34:32] == 3'($past(m_axis_tdata[34:32]) + 3'd1)))
        else $error("digest words not sent in order");

endmodule

bind sha256_stream_hasher_top shs_checker u_shs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
